/* src/dmad_pkg.sv */
// Shared types and constants for the drive mode arbiter with debounce.
package dmad_pkg;

  localparam logic [1:0] MODE_GLOBAL   = 2'd0;
  localparam logic [1:0] MODE_AVOID    = 2'd1;
  localparam logic [1:0] MODE_OVERTAKE = 2'd2;
  localparam logic [1:0] MODE_RSVD     = 2'd3;

  localparam logic [1:0] CFG_DEFAULT_MODE = 2'd0;
  localparam logic [1:0] CFG_PATH_CHECK   = 2'd1;
  localparam logic [1:0] CFG_MIN_DWELL    = 2'd2;
  localparam logic [1:0] CFG_CONFIRM      = 2'd3;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [1:0]  default_mode;
    logic        path_check_enable;
    logic [15:0] min_dwell_ms;
    logic [7:0]  confirm_ticks;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        obstacles_fresh;
    logic        static_blocks;
    logic        dynamic_blocks;
    logic        any_static;
    logic        any_dynamic;
    logic        avoid_fresh;
    logic        avoid_valid;
    logic        overtake_fresh;
    logic        overtake_valid;
  } item_t;

  typedef struct packed {
    logic [1:0] req;
    logic       avoid_ok;
    logic       over_ok;
  } request_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] requested_mode;
    logic       fell_back;
    logic       changed;
  } result_t;

endpackage

/* src/drive_mode_arbiter_debounce_unit.sv */
// Top level of the drive mode arbiter: configuration, input register and result register.
// Each input word is taken into an input register, its mode request and stability filter
// are worked out combinationally, and the result lands in an output register, so one word
// can be accepted in every clock cycle while out_ready does not stall the output; a result
// moves into the output register only when that register is free. The rate is set by the
// update of the filter state (committed mode, pending mode, confirmation count and time of
// the last change), which the next word reads. The user must write configuration through
// cfg_we, cfg_index and cfg_wdata only while no word is in flight; it is not enforced.
module drive_mode_arbiter_debounce_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_ms,
  input  logic        in_obstacles_fresh,
  input  logic        in_static_blocks,
  input  logic        in_dynamic_blocks,
  input  logic        in_any_static,
  input  logic        in_any_dynamic,
  input  logic        in_avoid_fresh,
  input  logic        in_avoid_valid,
  input  logic        in_overtake_fresh,
  input  logic        in_overtake_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_mode,
  output logic [1:0]  out_requested_mode,
  output logic        out_fell_back,
  output logic        out_changed
);

  dmad_pkg::cfg_t     cfg_r;
  dmad_pkg::item_t    item_r;
  dmad_pkg::request_t request;
  dmad_pkg::result_t  result;
  dmad_pkg::result_t  res_r;
  logic               s1_valid_r;
  logic               out_valid_r;
  logic               advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_mode      <= dmad_pkg::MODE_GLOBAL;
      cfg_r.path_check_enable <= 1'b1;
      cfg_r.min_dwell_ms      <= 16'd1000;
      cfg_r.confirm_ticks     <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        dmad_pkg::CFG_DEFAULT_MODE: cfg_r.default_mode      <= cfg_wdata[1:0];
        dmad_pkg::CFG_PATH_CHECK:   cfg_r.path_check_enable <= cfg_wdata[0];
        dmad_pkg::CFG_MIN_DWELL:    cfg_r.min_dwell_ms      <= cfg_wdata;
        dmad_pkg::CFG_CONFIRM:      cfg_r.confirm_ticks     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.now_ms          <= in_now_ms;
      item_r.obstacles_fresh <= in_obstacles_fresh;
      item_r.static_blocks   <= in_static_blocks;
      item_r.dynamic_blocks  <= in_dynamic_blocks;
      item_r.any_static      <= in_any_static;
      item_r.any_dynamic     <= in_any_dynamic;
      item_r.avoid_fresh     <= in_avoid_fresh;
      item_r.avoid_valid     <= in_avoid_valid;
      item_r.overtake_fresh  <= in_overtake_fresh;
      item_r.overtake_valid  <= in_overtake_valid;
    end
    if (advance) begin
      res_r <= result;
    end
  end

  dmad_request u_request (
    .cfg     (cfg_r),
    .item    (item_r),
    .request (request)
  );

  dmad_filter u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .cfg     (cfg_r),
    .now_ms  (item_r.now_ms),
    .request (request),
    .result  (result)
  );

  assign out_valid          = out_valid_r;
  assign out_mode           = res_r.mode;
  assign out_requested_mode = res_r.requested_mode;
  assign out_fell_back      = res_r.fell_back;
  assign out_changed        = res_r.changed;

  a_fallback_is_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fell_back |-> out_changed && out_mode == dmad_pkg::MODE_GLOBAL)
    else $error("fallback word without a change to global");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("waiting result word was overwritten");

endmodule

/* src/dmad_request.sv */
// Requested mode and path usability from the obstacle and path flags of one word.
module dmad_request (
  input  dmad_pkg::cfg_t     cfg,
  input  dmad_pkg::item_t    item,
  output dmad_pkg::request_t request
);

  logic       avoid_ok;
  logic       over_ok;
  logic       both;
  logic [1:0] dflt;

  assign avoid_ok = item.avoid_fresh && (!cfg.path_check_enable || item.avoid_valid);
  assign over_ok  = item.overtake_fresh && (!cfg.path_check_enable || item.overtake_valid);
  assign both     = item.any_static && item.any_dynamic
                    && (item.static_blocks || item.dynamic_blocks);
  assign dflt     = (cfg.default_mode == dmad_pkg::MODE_RSVD) ? dmad_pkg::MODE_GLOBAL
                                                              : cfg.default_mode;

  always_comb begin
    request.avoid_ok = avoid_ok;
    request.over_ok  = over_ok;
    if (item.obstacles_fresh && (both || item.static_blocks)) begin
      request.req = avoid_ok ? dmad_pkg::MODE_AVOID : dmad_pkg::MODE_GLOBAL;
    end else if (item.obstacles_fresh && item.dynamic_blocks) begin
      request.req = over_ok ? dmad_pkg::MODE_OVERTAKE : dmad_pkg::MODE_GLOBAL;
    end else if (dflt == dmad_pkg::MODE_AVOID) begin
      request.req = avoid_ok ? dmad_pkg::MODE_AVOID : dmad_pkg::MODE_GLOBAL;
    end else if (dflt == dmad_pkg::MODE_OVERTAKE) begin
      request.req = over_ok ? dmad_pkg::MODE_OVERTAKE : dmad_pkg::MODE_GLOBAL;
    end else begin
      request.req = dmad_pkg::MODE_GLOBAL;
    end
  end

endmodule

/* src/dmad_filter.sv */
// Stability filter: committed mode, pending request, confirmation count and dwell timer.
module dmad_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  dmad_pkg::cfg_t     cfg,
  input  logic [31:0]        now_ms,
  input  dmad_pkg::request_t request,
  output dmad_pkg::result_t  result
);

  logic [1:0]  committed_r, committed_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [31:0] last_change_r, last_change_nxt;
  logic        supported;
  logic        fell;
  logic [31:0] elapsed;

  assign elapsed = now_ms - last_change_r;

  always_comb begin
    case (committed_r)
      dmad_pkg::MODE_AVOID:    supported = request.avoid_ok;
      dmad_pkg::MODE_OVERTAKE: supported = request.over_ok;
      default:                 supported = 1'b1;
    endcase
  end

  always_comb begin
    committed_nxt   = committed_r;
    pending_nxt     = pending_r;
    count_nxt       = count_r;
    last_change_nxt = last_change_r;
    fell            = 1'b0;
    if (!supported) begin
      committed_nxt   = dmad_pkg::MODE_GLOBAL;
      last_change_nxt = now_ms;
      pending_nxt     = dmad_pkg::MODE_GLOBAL;
      count_nxt       = 8'd0;
      fell            = 1'b1;
    end else if (request.req == committed_r) begin
      pending_nxt = committed_r;
      count_nxt   = 8'd0;
    end else begin
      if (request.req != pending_r) begin
        pending_nxt = request.req;
        count_nxt   = 8'd1;
      end else if (count_r != dmad_pkg::COUNT_MAX) begin
        count_nxt = count_r + 8'd1;
      end
      if (elapsed >= {16'd0, cfg.min_dwell_ms} && count_nxt >= cfg.confirm_ticks) begin
        committed_nxt   = pending_nxt;
        last_change_nxt = now_ms;
        count_nxt       = 8'd0;
      end
    end
    result.mode           = committed_nxt;
    result.requested_mode = request.req;
    result.fell_back      = fell;
    result.changed        = committed_nxt != committed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r   <= dmad_pkg::MODE_GLOBAL;
      pending_r     <= dmad_pkg::MODE_GLOBAL;
      count_r       <= 8'd0;
      last_change_r <= 32'd0;
    end else if (en) begin
      committed_r   <= committed_nxt;
      pending_r     <= pending_nxt;
      count_r       <= count_nxt;
      last_change_r <= last_change_nxt;
    end
  end

  a_committed_legal: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r != dmad_pkg::MODE_RSVD)
    else $error("committed mode holds the reserved code");

  a_fallback_restarts_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    en && fell |=> last_change_r == $past(now_ms) && count_r == 8'd0
                   && committed_r == dmad_pkg::MODE_GLOBAL)
    else $error("fallback did not restart the dwell timer");

  a_change_restarts_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    en && result.changed |=> last_change_r == $past(now_ms))
    else $error("mode change did not record its time");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(committed_r) && $stable(count_r) && $stable(pending_r))
    else $error("filter state moved without a word");

endmodule
